FILE: rtl/ffba_pkg.sv
// Shared constants for the first-fit block allocator.
// Field widths, status codes, opcodes and default pool parameters.
// No dependencies.
package ffba_pkg;

    localparam int POOL_BYTES_DEF   = 32768;
    localparam int HEADER_BYTES_DEF = 32;
    localparam int MAX_BLOCKS_DEF   = 1024;

    localparam int REQ_W    = 15;
    localparam int OFFSET_W = 15;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 11;
    localparam int ALIGN_W  = 16;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MEM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd3;

endpackage

FILE: rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: block record memory and sequencer.
// Depends on ffba_pkg.

// One request is handled at a time, from the accepting cycle through the cycle
// that loads the result register. An allocate walks the block records from the
// start until the first free block that fits, one record per cycle through the
// single read port of the record memory. When it splits a block it moves every
// later record up by one, one record per cycle, then writes two records. A free
// walks to the block, then makes a full merge pass over all records, one per
// cycle, and writes the last merged record. A failed search ends at the last
// record, and a zero-size allocate goes straight to the result. block_count can
// reach MAX_BLOCKS. After reset the initial free block is written before the
// first request is taken. A new request is taken while the previous result still
// waits on the output, and the finished request then holds until that result is
// taken.
module first_fit_block_allocator #(
    parameter int POOL_BYTES   = ffba_pkg::POOL_BYTES_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [14:0] request_bytes, [29:15] release_offset, [31:30] zero
    input  logic [ffba_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] opcode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [16:2] payload_offset, [27:17] live_allocations, [31:28] zero
    output logic [ffba_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int SW = $clog2(POOL_BYTES);
    localparam int RW = SW + 1;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = IW + 1;
    localparam int OW = SW + 1;
    localparam int XW = (OW > ffba_pkg::ALIGN_W + 1) ? OW : ffba_pkg::ALIGN_W + 1;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SEARCH = 4'd2;
    localparam logic [3:0] S_SHIFT  = 4'd3;
    localparam logic [3:0] S_WR_NEW = 4'd4;
    localparam logic [3:0] S_WR_HIT = 4'd5;
    localparam logic [3:0] S_MERGE  = 4'd6;
    localparam logic [3:0] S_FLUSH  = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    // record: [SW] free mark, [SW-1:0] payload size
    logic [RW-1:0] mem [MAX_BLOCKS];
    logic [RW-1:0] r_rd_data;
    logic          rd_en, we;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [RW-1:0] wr_data;

    logic [3:0]   r_state, n_state;
    logic         r_op, n_op;
    logic [ffba_pkg::ALIGN_W-1:0] r_aligned, n_aligned;
    logic [ffba_pkg::OFFSET_W-1:0] r_rel, n_rel;
    logic [CW-1:0] r_ridx, n_ridx;
    logic          r_dv, n_dv;
    logic [IW-1:0] r_didx, n_didx;
    logic [OW-1:0] r_off, n_off;
    logic [IW-1:0] r_hit, n_hit;
    logic [SW-1:0] r_hsize, n_hsize;
    logic [SW-1:0] r_rem, n_rem;
    logic          r_split, n_split;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_alloc, n_alloc;
    logic [RW-1:0] r_wrec, n_wrec;
    logic [CW-1:0] r_w, n_w;
    logic [ffba_pkg::STATUS_W-1:0] r_status, n_status;
    logic [ffba_pkg::OFFSET_W-1:0] r_payload, n_payload;
    logic          r_ovalid, n_ovalid;
    logic [ffba_pkg::STATUS_W-1:0] r_ostatus, n_ostatus;
    logic [ffba_pkg::OFFSET_W-1:0] r_opay, n_opay;
    logic [ffba_pkg::LIVE_W-1:0]   r_olive, n_olive;

    logic          rec_free;
    logic [SW-1:0] rec_size;
    logic [RW-1:0] rec_m;
    logic [XW-1:0] rem_x;
    logic          is_last;
    logic          s_acc;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign rec_free = r_rd_data[SW];
    assign rec_size = r_rd_data[SW-1:0];
    assign rem_x    = XW'(rec_size) - XW'(r_aligned);
    assign is_last  = (CW'(r_didx) == r_cnt - CW'(1));
    assign s_acc    = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_olive, r_opay, r_ostatus};

    always_comb begin
        n_state = r_state;   n_op = r_op;       n_aligned = r_aligned;
        n_rel = r_rel;       n_ridx = r_ridx;   n_dv = r_dv;
        n_didx = r_didx;     n_off = r_off;     n_hit = r_hit;
        n_hsize = r_hsize;   n_rem = r_rem;     n_split = r_split;
        n_cnt = r_cnt;       n_alloc = r_alloc; n_wrec = r_wrec;
        n_w = r_w;           n_status = r_status; n_payload = r_payload;
        n_ovalid = r_ovalid; n_ostatus = r_ostatus;
        n_opay = r_opay;     n_olive = r_olive;
        rd_en = 1'b0;  rd_addr = r_ridx[IW-1:0];
        we = 1'b0;     wr_addr = r_hit;  wr_data = r_wrec;
        rec_m = r_rd_data;
        if (r_didx == r_hit) begin
            rec_m[SW] = 1'b1;
        end

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                we      = 1'b1;
                wr_addr = '0;
                wr_data = {1'b1, SW'(POOL_BYTES - HEADER_BYTES)};
                n_cnt   = CW'(1);
                n_alloc = '0;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_acc) begin
                    n_op      = s_axis_tuser;
                    n_aligned = (ffba_pkg::ALIGN_W'(s_axis_tdata[14:0]) +
                                 ffba_pkg::ALIGN_W'(7)) & ~ffba_pkg::ALIGN_W'(7);
                    n_rel     = s_axis_tdata[29:15];
                    n_status  = ffba_pkg::ST_OK;
                    n_payload = '0;
                    n_ridx    = '0;
                    n_dv      = 1'b0;
                    n_off     = '0;
                    if (s_axis_tuser == ffba_pkg::OP_ALLOC && s_axis_tdata[14:0] == '0) begin
                        n_status = ffba_pkg::ST_ZERO;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                n_dv = 1'b0;
                if (r_ridx < r_cnt) begin
                    rd_en  = 1'b1;
                    n_didx = r_ridx[IW-1:0];
                    n_dv   = 1'b1;
                    n_ridx = r_ridx + CW'(1);
                end
                if (r_dv) begin
                    if (r_op == ffba_pkg::OP_ALLOC && rec_free &&
                        XW'(rec_size) >= XW'(r_aligned)) begin
                        n_hit     = r_didx;
                        n_hsize   = rec_size;
                        n_payload = ffba_pkg::OFFSET_W'(r_off + OW'(HEADER_BYTES));
                        n_rem     = SW'(rem_x - XW'(HEADER_BYTES));
                        n_split   = (rem_x >= XW'(HEADER_BYTES + 8)) &&
                                    (r_cnt < CW'(MAX_BLOCKS));
                        n_alloc   = r_alloc + CW'(1);
                        n_ridx    = r_cnt - CW'(1);
                        n_dv      = 1'b0;
                        n_state   = ((rem_x >= XW'(HEADER_BYTES + 8)) &&
                                     (r_cnt < CW'(MAX_BLOCKS))) ? S_SHIFT : S_WR_HIT;
                    end else if (r_op == ffba_pkg::OP_FREE && !rec_free &&
                                 XW'(r_off) + XW'(HEADER_BYTES) == XW'(r_rel)) begin
                        n_hit   = r_didx;
                        if (r_alloc != '0) begin
                            n_alloc = r_alloc - CW'(1);
                        end
                        n_ridx  = '0;
                        n_dv    = 1'b0;
                        n_state = S_MERGE;
                    end else begin
                        n_off = r_off + OW'(HEADER_BYTES) + OW'(rec_size);
                        if (is_last) begin
                            n_status = (r_op == ffba_pkg::OP_ALLOC) ?
                                       ffba_pkg::ST_NO_MEM : ffba_pkg::ST_BAD_FREE;
                            n_state  = S_FIN;
                        end
                    end
                end
            end
            S_SHIFT: begin
                // move records above the hit up by one, top first
                if (r_dv) begin
                    we      = 1'b1;
                    wr_addr = r_didx + IW'(1);
                    wr_data = r_rd_data;
                end
                if (r_ridx[IW-1:0] != r_hit) begin
                    rd_en  = 1'b1;
                    n_didx = r_ridx[IW-1:0];
                    n_dv   = 1'b1;
                    n_ridx = r_ridx - CW'(1);
                end else begin
                    n_dv = 1'b0;
                    if (!r_dv) begin
                        n_state = S_WR_NEW;
                    end
                end
            end
            S_WR_NEW: begin
                we      = 1'b1;
                wr_addr = r_hit + IW'(1);
                wr_data = {1'b1, r_rem};
                n_cnt   = r_cnt + CW'(1);
                n_state = S_WR_HIT;
            end
            S_WR_HIT: begin
                we      = 1'b1;
                wr_addr = r_hit;
                wr_data = {1'b0, r_split ? SW'(r_aligned) : r_hsize};
                n_state = S_FIN;
            end
            S_MERGE: begin
                n_dv = 1'b0;
                if (r_ridx < r_cnt) begin
                    rd_en  = 1'b1;
                    n_didx = r_ridx[IW-1:0];
                    n_dv   = 1'b1;
                    n_ridx = r_ridx + CW'(1);
                end
                if (r_dv) begin
                    if (r_didx == '0) begin
                        n_wrec = rec_m;
                        n_w    = '0;
                    end else if (r_wrec[SW] && rec_m[SW]) begin
                        n_wrec = {1'b1, r_wrec[SW-1:0] + SW'(HEADER_BYTES) + rec_m[SW-1:0]};
                    end else begin
                        we      = 1'b1;
                        wr_addr = r_w[IW-1:0];
                        wr_data = r_wrec;
                        n_w     = r_w + CW'(1);
                        n_wrec  = rec_m;
                    end
                    if (is_last) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                we      = 1'b1;
                wr_addr = r_w[IW-1:0];
                wr_data = r_wrec;
                n_cnt   = r_w + CW'(1);
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_opay    = r_payload;
                    n_olive   = ffba_pkg::LIVE_W'(r_alloc);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ovalid <= 1'b0;
            r_dv     <= 1'b0;
            r_cnt    <= CW'(1);
            r_alloc  <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_dv     <= n_dv;
            r_cnt    <= n_cnt;
            r_alloc  <= n_alloc;
        end
        r_op      <= n_op;
        r_aligned <= n_aligned;
        r_rel     <= n_rel;
        r_ridx    <= n_ridx;
        r_didx    <= n_didx;
        r_off     <= n_off;
        r_hit     <= n_hit;
        r_hsize   <= n_hsize;
        r_rem     <= n_rem;
        r_split   <= n_split;
        r_wrec    <= n_wrec;
        r_w       <= n_w;
        r_status  <= n_status;
        r_payload <= n_payload;
        r_ostatus <= n_ostatus;
        r_opay    <= n_opay;
        r_olive   <= n_olive;
    end

endmodule

FILE: rtl/ffba_checker.sv
// Port-level checks for the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator.
module ffba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [ffba_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // a held result must not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // only an ok status carries an offset
    a_pay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ffba_pkg::ST_OK |-> m_axis_tdata[16:2] == '0)
        else $error("offset on failed request");

    // one request at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("took a request while busy");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("activity right after reset");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
